// ===== rtl/wpa_pkg.sv =====
`timescale 1ns / 1ps

package wpa_pkg;

	localparam logic [10:0] MAX_POOL = 11'd1024;

	localparam int DIVIDEND_W = 48;
	localparam int DIVISOR_W  = 16;
	// quotient bits retired per cycle by the shared divider
	localparam int DIV_RADIX_BITS = 2;
	localparam int DIV_STEPS      = DIVIDEND_W / DIV_RADIX_BITS;

	localparam int HOLD_US_W = 31;
	localparam logic [HOLD_US_W-1:0] US_PER_MS = 31'd1000;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_MIN_WORKERS  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_WORKERS  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GROW_STEP    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_HOLD_MS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_POLL_MS      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_POLL_DIVISOR = 3'd5;

	localparam logic [15:0] QUIET_DEFAULT_MS = 16'd10;

	typedef struct packed {
		logic [10:0]          min_workers;
		logic [10:0]          max_workers;
		logic [10:0]          grow_step;
		logic [19:0]          idle_hold_ms;
		logic [15:0]          poll_ms;
		logic [15:0]          poll_divisor;
		logic [HOLD_US_W-1:0] hold_us;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BASE,
		S_BASE_WAIT,
		S_EVAL,
		S_GROW,
		S_SHRINK,
		S_SHRINK_WAIT,
		S_DONE
	} state_t;

endpackage

// ===== rtl/wpa_div.sv =====
`timescale 1ns / 1ps

module wpa_div
	import wpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;

	logic [DIVISOR_W:0]    r1, r2;
	logic                  ge1, ge2;
	logic [DIVISOR_W-1:0]  n1, n2;

	// two restoring steps per cycle, remainder always stays below the divisor
	always_comb begin
		r1  = {rem_q, quo_q[DIVIDEND_W-1]};
		ge1 = r1 >= {1'b0, div_q};
		n1  = ge1 ? DIVISOR_W'(r1 - {1'b0, div_q}) : r1[DIVISOR_W-1:0];
		r2  = {n1, quo_q[DIVIDEND_W-2]};
		ge2 = r2 >= {1'b0, div_q};
		n2  = ge2 ? DIVISOR_W'(r2 - {1'b0, div_q}) : r2[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-3:0], ge1, ge2};
			rem_q <= n2;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/wpa_cfg.sv =====
`timescale 1ns / 1ps

module wpa_cfg
	import wpa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output cfg_t                   cfg
);

	logic [10:0]          min_q, max_q, step_q;
	logic [19:0]          hold_ms_q;
	logic [15:0]          poll_q, pdiv_q;
	logic [HOLD_US_W-1:0] hold_us_q;
	logic [10:0]          sat_val;

	assign sat_val = (wr_data[10:0] > MAX_POOL) ? MAX_POOL : wr_data[10:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= 11'd2;
			max_q     <= 11'd16;
			step_q    <= 11'd0;
			hold_ms_q <= 20'd5000;
			poll_q    <= 16'd0;
			pdiv_q    <= 16'd100;
			hold_us_q <= 31'd5001000;
		end else begin
			// shrink allowed once elapsed_us >= (hold_ms + 1) * 1000
			hold_us_q <= ({11'd0, hold_ms_q} + 31'd1) * US_PER_MS;
			if (wr_en) begin
				unique case (wr_index)
					REG_MIN_WORKERS:  min_q     <= (sat_val > max_q) ? max_q : sat_val;
					REG_MAX_WORKERS:  max_q     <= (sat_val < min_q) ? min_q : sat_val;
					REG_GROW_STEP:    step_q    <= wr_data[10:0];
					REG_IDLE_HOLD_MS: hold_ms_q <= wr_data[19:0];
					REG_POLL_MS:      poll_q    <= wr_data[15:0];
					REG_POLL_DIVISOR: pdiv_q    <= wr_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		cfg.min_workers  = min_q;
		cfg.max_workers  = max_q;
		cfg.grow_step    = step_q;
		cfg.idle_hold_ms = hold_ms_q;
		cfg.poll_ms      = poll_q;
		cfg.poll_divisor = pdiv_q;
		cfg.hold_us      = hold_us_q;
	end

endmodule

// ===== rtl/worker_pool_autoscaler.sv =====
`timescale 1ns / 1ps

// worker pool autoscaler
// s_* carries one load sample per request, m_* returns exactly one result per
// sample: m_tuser flags a resize command, m_tdata holds the new size and the
// sleep time in ms. cfg_* writes the limit and timing registers; it is always
// ready; the user must write it only while no sample is in flight, the block
// itself does not enforce this. one sample at a time goes through a sequencer
// around a shared radix-4 divider (24 steps). the derived wait takes one
// division (skipped when poll_ms is nonzero), the shrink path may take a second
// one for idle/pending. the result is loaded into the output register from the
// done state once that register is empty or being read; the next sample can be
// accepted in the cycle after that load.
// a finished result sits in the output register, so a new sample is accepted
// while the receiver stalls; the sequencer holds its next result until the
// output register empties.
// reset restores the register defaults and clears the resize and wait
// timestamps and the remembered pool size.
module worker_pool_autoscaler
	import wpa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// pool_size[10:0], busy_count[21:11], free_count[32:22], pending_count[48:33],
	// now_us[96:49], zero fill above
	input  logic [103:0]           s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// new_size[10:0], sleep_ms[27:11], zero fill above
	output logic [31:0]            m_tdata,
	// resize_valid[0]
	output logic                   m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg;

	state_t state_q, state_d;

	logic [10:0] pool_q, busy_q, free_q;
	logic [15:0] pend_q;
	logic [47:0] now_q;

	logic [47:0] last_resize_q, last_wait_q;
	logic [10:0] prev_pool_q;

	logic [15:0] base_q;
	logic        rv_q;
	logic [10:0] ns_q;
	logic [16:0] sleep_q;
	logic [16:0] need_q;
	logic [15:0] lim_q;

	logic        out_valid_q;
	logic        out_rv_q;
	logic [10:0] out_ns_q;
	logic [16:0] out_sleep_q;

	logic                  dv_start, dv_done;
	logic [DIVIDEND_W-1:0] dv_dividend, dv_quot;
	logic [DIVISOR_W-1:0]  dv_divisor, dv_rem;

	logic        in_take, out_load;
	logic        clamp, grow;
	logic [16:0] demand, need;
	logic [15:0] half, lim;
	logic [16:0] add;
	logic [17:0] sum;
	logic [10:0] grow_target;
	logic [47:0] elapsed;
	logic        hold_ok;
	logic [10:0] idle;
	logic        shrink_go, quiet;
	logic [10:0] shr_sub, shr_target;

	assign cfg_ready = 1'b1;

	wpa_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	wpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (dv_start),
		.dividend  (dv_dividend),
		.divisor   (dv_divisor),
		.done      (dv_done),
		.quotient  (dv_quot),
		.remainder (dv_rem)
	);

	assign s_tready = (state_q == S_IDLE);
	assign in_take  = s_tvalid && s_tready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	// decision datapath
	always_comb begin
		clamp  = (pool_q < cfg.min_workers) || (pool_q > cfg.max_workers);
		grow   = pend_q > {5'd0, free_q};
		demand = {6'd0, busy_q} + {1'b0, pend_q};
		need   = (demand > {6'd0, pool_q}) ? 17'(demand - {6'd0, pool_q}) : 17'd0;
		half   = pend_q >> 1;
		if (cfg.grow_step != 11'd0) lim = {5'd0, cfg.grow_step};
		else                        lim = (half == 16'd0) ? 16'd1 : half;

		add         = (need_q < {1'b0, lim_q}) ? need_q : {1'b0, lim_q};
		sum         = {7'd0, pool_q} + {1'b0, add};
		grow_target = (sum > {7'd0, cfg.max_workers}) ? cfg.max_workers : sum[10:0];

		elapsed   = now_q - last_resize_q;
		hold_ok   = elapsed >= {17'd0, cfg.hold_us};
		idle      = (busy_q > pool_q) ? 11'd0 : 11'(pool_q - busy_q);
		shrink_go = hold_ok && (idle > cfg.min_workers);
		quiet     = (pool_q == prev_pool_q) && (pend_q == 16'd0);

		shr_sub    = pool_q - dv_quot[10:0];
		shr_target = (shr_sub < cfg.min_workers) ? cfg.min_workers : shr_sub;
	end

	// divider operands
	always_comb begin
		dv_start = 1'b0;
		if (state_q == S_BASE) begin
			dv_start    = (cfg.poll_ms == 16'd0);
			dv_dividend = now_q - last_wait_q;
			dv_divisor  = (cfg.poll_divisor == 16'd0) ? 16'd1 : cfg.poll_divisor;
		end else begin
			dv_start    = (state_q == S_SHRINK) && shrink_go;
			dv_dividend = {37'd0, idle};
			dv_divisor  = (pend_q == 16'd0) ? 16'd1 : pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:        if (in_take) state_d = S_BASE;
			S_BASE:        state_d = (cfg.poll_ms == 16'd0) ? S_BASE_WAIT : S_EVAL;
			S_BASE_WAIT:   if (dv_done) state_d = S_EVAL;
			S_EVAL: begin
				if (clamp)     state_d = S_DONE;
				else if (grow) state_d = S_GROW;
				else           state_d = S_SHRINK;
			end
			S_GROW:        state_d = S_DONE;
			S_SHRINK:      state_d = shrink_go ? S_SHRINK_WAIT : S_DONE;
			S_SHRINK_WAIT: if (dv_done) state_d = S_DONE;
			S_DONE:        if (out_load) state_d = S_IDLE;
			default:       state_d = S_IDLE;
		endcase
	end

	// sample registers and working results
	always_ff @(posedge clk) begin
		if (in_take) begin
			pool_q <= s_tdata[10:0];
			busy_q <= s_tdata[21:11];
			free_q <= s_tdata[32:22];
			pend_q <= s_tdata[48:33];
			now_q  <= s_tdata[96:49];
			rv_q   <= 1'b0;
			ns_q   <= 11'd0;
		end
		if (state_q == S_BASE && cfg.poll_ms != 16'd0) base_q <= cfg.poll_ms;
		if (state_q == S_BASE_WAIT && dv_done)
			base_q <= (dv_rem == 16'd0) ? QUIET_DEFAULT_MS : dv_rem;
		if (state_q == S_EVAL) begin
			need_q  <= need;
			lim_q   <= lim;
			sleep_q <= {1'b0, base_q};
			if (clamp) begin
				rv_q <= 1'b1;
				ns_q <= (pool_q < cfg.min_workers) ? cfg.min_workers : cfg.max_workers;
			end
		end
		if (state_q == S_GROW && grow_target != pool_q) begin
			rv_q <= 1'b1;
			ns_q <= grow_target;
		end
		if (state_q == S_SHRINK) sleep_q <= quiet ? {base_q, 1'b0} : {1'b0, base_q};
		if (state_q == S_SHRINK_WAIT && dv_done && shr_target != pool_q) begin
			rv_q <= 1'b1;
			ns_q <= shr_target;
		end
	end

	// timestamps and remembered pool size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_resize_q <= '0;
			last_wait_q   <= '0;
			prev_pool_q   <= '0;
		end else begin
			if (state_q == S_EVAL && clamp) begin
				last_resize_q <= now_q;
				last_wait_q   <= now_q;
			end
			if (state_q == S_GROW && grow_target != pool_q) last_resize_q <= now_q;
			if (state_q == S_SHRINK) begin
				last_wait_q <= now_q;
				prev_pool_q <= pool_q;
			end
			if (state_q == S_SHRINK_WAIT && dv_done && shr_target != pool_q)
				last_resize_q <= now_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rv_q    <= rv_q;
			out_ns_q    <= ns_q;
			out_sleep_q <= sleep_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_rv_q;
	assign m_tdata  = {4'd0, out_sleep_q, out_ns_q};

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (state_q == S_BASE_WAIT || state_q == S_SHRINK_WAIT))
		else $error("divider finished outside a wait state");

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == S_BASE))
		else $error("accepted sample did not start the sequence");

	a_size_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			(out_ns_q >= cfg.min_workers && out_ns_q <= cfg.max_workers))
		else $error("commanded size outside the pool limits");

	a_no_size_without_resize: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (out_ns_q == 11'd0))
		else $error("size reported without a resize");

	a_sleep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_sleep_q != 17'd0))
		else $error("zero sleep interval");

endmodule
